// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pair-sum query block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define SPSQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// An implication checked in the same cycle.
`define SPSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// An implication whose consequent is checked in the next cycle.
`define SPSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPSQ_ASSERT(lbl, clk, rst_n, prop)
`define SPSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/spsq_pkg.sv -----
// ----------------------------------------------------------------------------
// spsq_pkg
// Types and constants of the sorted pair-sum query block.
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                      found;
		logic signed [VALUE_W-1:0] first_value;
		logic signed [VALUE_W-1:0] second_value;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_SUB,
		ST_P_RD,
		ST_P_CMP,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_pair_sum_query.sv -----
// ----------------------------------------------------------------------------
// sorted_pair_sum_query
// Sorted value table with insert, clear and pair-sum lookup.
// ----------------------------------------------------------------------------
//
// Channel   Signals                    Direction  Contents
// cmd       cmd_valid/cmd_ready/cmd    in         op and value (load or target)
// res       res_valid/res_ready/res    out        found, first and second value
//
// A clear, an unused op or a load into a full table is handled in the idle state
// alone. A load shifts up every stored entry greater than the value, one at a time
// from the end; each shift is one table read and one write. A query reads, compares
// and subtracts each candidate, then seeks its partner by binary search, each probe
// a read and a compare, closed by a last check. Reset clears the state, the count
// and the result valid flag; the table is not swept. A finished result waits in the
// output register while the next item is accepted, and the block holds its last
// state until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_pair_sum_query #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire spsq_pkg::cmd_t   cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output spsq_pkg::res_t        res
);

	localparam int VW = spsq_pkg::VALUE_W;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	spsq_pkg::state_t state_q, state_d;

	// Control registers.
	logic [CW-1:0]        count_q;
	logic                 res_valid_q;

	// Working registers of the current item.
	logic signed [VW-1:0] val_q;
	logic        [AW-1:0] pos_q;
	logic        [CW-1:0] j_q;
	logic signed [VW-1:0] a_q;
	logic signed [VW-1:0] b_q;
	logic        [CW-1:0] lo_q;
	logic        [CW-1:0] hi_q;
	logic        [CW-1:0] mid_q;
	logic                 found_q;
	spsq_pkg::res_t       res_q;

	// Table port and shared unit.
	logic                 mem_we;
	logic        [AW-1:0] mem_waddr;
	logic        [VW-1:0] mem_wdata;
	logic        [AW-1:0] mem_raddr;
	logic        [VW-1:0] mem_rdata;
	logic signed [VW-1:0] alu_x;
	logic signed [VW-1:0] alu_y;
	logic signed [VW:0]   alu_diff;
	logic                 alu_lt;
	logic                 alu_eq;

	logic                 accept;
	logic                 out_free;
	logic                 insert_gt;
	logic                 ins_done;
	logic                 in_range;
	logic                 b_is_a;
	logic                 probe_done;
	logic                 scan_end;
	logic        [CW:0]   mid_sum;
	logic        [CW-1:0] mid;

	// State groups and full loads watched by the checks at the module's end.
	logic                 querying;
	logic                 probing;
	logic                 finishing;
	logic                 full_load;

	spsq_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	spsq_alu u_alu (
		.x    (alu_x),
		.y    (alu_y),
		.diff (alu_diff),
		.lt   (alu_lt),
		.eq   (alu_eq)
	);

	assign cmd_ready = (state_q == spsq_pkg::ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A stored entry moves up when it is strictly greater, so equal values keep
	// their order of arrival.
	assign insert_gt  = !alu_lt && !alu_eq;

	// The partner t - a is only a candidate if it fits in 32 signed bits.
	assign in_range   = (alu_diff[VW] == alu_diff[VW-1]);
	assign b_is_a     = (alu_diff[VW-1:0] == a_q);
	assign probe_done = (lo_q == hi_q);
	assign scan_end   = (j_q == count_q);
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CW:1];

	assign querying  = state_q inside {spsq_pkg::ST_Q_RD, spsq_pkg::ST_Q_CMP,
		spsq_pkg::ST_Q_SUB, spsq_pkg::ST_P_RD, spsq_pkg::ST_P_CMP, spsq_pkg::ST_FINISH};
	assign probing   = state_q inside {spsq_pkg::ST_P_RD, spsq_pkg::ST_P_CMP};
	assign finishing = (state_q == spsq_pkg::ST_FINISH);
	assign full_load = accept && cmd.op == spsq_pkg::OP_LOAD && count_q == DEPTH_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table port and shared unit operands.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = val_q;
		mem_raddr = '0;
		alu_x     = mem_rdata;
		alu_y     = val_q;
		ins_done  = 1'b0;
		case (state_q)
			spsq_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						spsq_pkg::OP_LOAD: begin
							if (count_q != DEPTH_C) begin
								state_d = spsq_pkg::ST_INS_RD;
							end
						end
						spsq_pkg::OP_QUERY: begin
							state_d = spsq_pkg::ST_Q_RD;
						end
						default: begin
							state_d = spsq_pkg::ST_IDLE;
						end
					endcase
				end
			end
			spsq_pkg::ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we   = 1'b1;
					ins_done = 1'b1;
					state_d  = spsq_pkg::ST_IDLE;
				end else begin
					mem_raddr = pos_q - AW'(1);
					state_d   = spsq_pkg::ST_INS_CMP;
				end
			end
			spsq_pkg::ST_INS_CMP: begin
				mem_we = 1'b1;
				if (insert_gt) begin
					mem_wdata = mem_rdata;
					state_d   = spsq_pkg::ST_INS_RD;
				end else begin
					ins_done = 1'b1;
					state_d  = spsq_pkg::ST_IDLE;
				end
			end
			spsq_pkg::ST_Q_RD: begin
				if (scan_end) begin
					state_d = spsq_pkg::ST_FINISH;
				end else begin
					mem_raddr = j_q[AW-1:0];
					state_d   = spsq_pkg::ST_Q_CMP;
				end
			end
			spsq_pkg::ST_Q_CMP: begin
				if (alu_lt) begin
					state_d = spsq_pkg::ST_Q_SUB;
				end else begin
					state_d = spsq_pkg::ST_FINISH;
				end
			end
			spsq_pkg::ST_Q_SUB: begin
				alu_x = val_q;
				alu_y = a_q;
				if (in_range && !b_is_a) begin
					state_d = spsq_pkg::ST_P_RD;
				end else begin
					state_d = spsq_pkg::ST_Q_RD;
				end
			end
			spsq_pkg::ST_P_RD: begin
				if (probe_done) begin
					state_d = spsq_pkg::ST_Q_RD;
				end else begin
					mem_raddr = mid[AW-1:0];
					state_d   = spsq_pkg::ST_P_CMP;
				end
			end
			spsq_pkg::ST_P_CMP: begin
				alu_y = b_q;
				if (alu_eq) begin
					state_d = spsq_pkg::ST_FINISH;
				end else begin
					state_d = spsq_pkg::ST_P_RD;
				end
			end
			spsq_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = spsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spsq_pkg::ST_IDLE;
			end
		endcase
	end

	// Entry count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept && cmd.op == spsq_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (ins_done) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == spsq_pkg::ST_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			spsq_pkg::ST_IDLE: begin
				if (accept) begin
					val_q   <= cmd.value;
					pos_q   <= count_q[AW-1:0];
					j_q     <= '0;
					found_q <= 1'b0;
				end
			end
			spsq_pkg::ST_INS_CMP: begin
				if (insert_gt) begin
					pos_q <= pos_q - AW'(1);
				end
			end
			spsq_pkg::ST_Q_CMP: begin
				a_q <= mem_rdata;
			end
			spsq_pkg::ST_Q_SUB: begin
				b_q  <= alu_diff[VW-1:0];
				lo_q <= '0;
				hi_q <= count_q;
				if (!in_range || b_is_a) begin
					j_q <= j_q + CW'(1);
				end
			end
			spsq_pkg::ST_P_RD: begin
				if (probe_done) begin
					j_q <= j_q + CW'(1);
				end else begin
					mid_q <= mid;
				end
			end
			spsq_pkg::ST_P_CMP: begin
				if (alu_eq) begin
					found_q <= 1'b1;
				end else if (alu_lt) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			spsq_pkg::ST_FINISH: begin
				if (out_free) begin
					res_q.found        <= found_q;
					res_q.first_value  <= found_q ? a_q : '0;
					res_q.second_value <= found_q ? b_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	`SPSQ_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C)
	`SPSQ_ASSERT_IMP(a_scan_bound, clk, arst_n, querying, j_q <= count_q)
	`SPSQ_ASSERT_IMP(a_probe_window, clk, arst_n, probing, lo_q <= hi_q && hi_q <= count_q)
	`SPSQ_ASSERT_NXT(a_full_load, clk, arst_n, full_load, $stable(count_q))
	`SPSQ_ASSERT_IMP(a_pair_distinct, clk, arst_n, finishing && found_q, b_q != a_q)

endmodule

`default_nettype wire

// ----- rtl/spsq_ram.sv -----
// ----------------------------------------------------------------------------
// spsq_ram
// Single write port, single read port table store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [AW-1:0]                     waddr,
	input  wire logic [spsq_pkg::VALUE_W-1:0]      wdata,
	input  wire logic [AW-1:0]                     raddr,
	output logic      [spsq_pkg::VALUE_W-1:0]      rdata
);

	logic [spsq_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/spsq_alu.sv -----
// ----------------------------------------------------------------------------
// spsq_alu
// Shared signed subtract and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_alu (
	input  wire logic signed [spsq_pkg::VALUE_W-1:0] x,
	input  wire logic signed [spsq_pkg::VALUE_W-1:0] y,
	output logic      signed [spsq_pkg::VALUE_W:0]   diff,
	output logic                                     lt,
	output logic                                     eq
);

	// The difference is one bit wider, so it never wraps.
	assign diff = {x[spsq_pkg::VALUE_W-1], x} - {y[spsq_pkg::VALUE_W-1], y};
	assign lt   = diff[spsq_pkg::VALUE_W];
	assign eq   = (x == y);

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for sorted_pair_sum_query
// Sends clear, load, query and unused items through the command channel and
// checks every pair-sum answer against a behavioural table model.
// ----------------------------------------------------------------------------

module testbench;

	localparam int TABLE_DEPTH = 1024;
	// The biggest table the random traffic builds; it keeps queries short.
	localparam int RANDOM_TABLE_MAX = 28;
	// Entries loaded by the large-table test before its long walks.
	localparam int LARGE_TABLE_FILL = 192;
	// A load that lands at the front shifts every stored entry.
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 64;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int VALUE_MIN = 32'sh8000_0000;
	localparam int VALUE_MAX = 32'sh7fff_ffff;
	// The one op code that the package leaves unnamed.
	localparam logic [1:0] OP_UNUSED_CODE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	spsq_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	spsq_pkg::res_t res;

	// Contents of the block's table as the model sees it, kept in ascending order.
	int table_model[$];
	// Answers owed by the block, oldest first.
	spsq_pkg::res_t pending_answers[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	sorted_pair_sum_query #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The run is abandoned if it takes far longer than the slowest correct
	// run could; a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------

	// Walks the stored values a in ascending order while a is below the
	// target, and answers with the first a whose partner target - a is
	// stored and differs from a. The partner is formed in 64 bits, so a
	// partner outside the 32-bit range simply cannot be found.
	function automatic spsq_pkg::res_t pair_sum_answer(int target);
		spsq_pkg::res_t answer;
		longint a;
		longint b;
		bit hit;
		answer = '0;
		for (int j = 0; j < table_model.size() && !answer.found; j++) begin
			a = table_model[j];
			hit = 1'b0;
			if (a < target) begin
				b = longint'(target) - a;
				if (b >= longint'(VALUE_MIN) && b <= longint'(VALUE_MAX) && b != a) begin
					for (int k = 0; k < table_model.size(); k++) begin
						if (longint'(table_model[k]) == b)
							hit = 1'b1;
					end
				end
			end
			if (hit) begin
				answer.found = 1'b1;
				answer.first_value = a[31:0];
				answer.second_value = b[31:0];
			end
		end
		return answer;
	endfunction

	// Applies an accepted item to the model and records any answer it owes.
	function automatic void apply_to_table_model(spsq_pkg::cmd_t item);
		int pos;
		case (item.op)
			spsq_pkg::OP_CLEAR: begin
				table_model.delete();
			end
			spsq_pkg::OP_LOAD: begin
				// A full table ignores the load. Equal values go after the
				// ones already stored.
				if (table_model.size() < TABLE_DEPTH) begin
					pos = table_model.size();
					while (pos > 0 && table_model[pos-1] > int'(item.value))
						pos--;
					table_model.insert(pos, int'(item.value));
				end
			end
			spsq_pkg::OP_QUERY: begin
				pending_answers.push_back(pair_sum_answer(int'(item.value)));
			end
			default: begin
				// The unused code leaves everything as it was.
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------

	// Called just after a rising edge. An idle gap, if drawn, lowers valid
	// first; otherwise valid stays high from the previous item so that it is
	// never lowered and raised in the same step.
	task automatic send_cmd(input spsq_pkg::cmd_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do
			@(posedge clk);
		while (!cmd_ready);
		apply_to_table_model(item);
	endtask

	task automatic clear_table();
		spsq_pkg::cmd_t item;
		item.op = spsq_pkg::OP_CLEAR;
		item.value = $urandom;
		send_cmd(item);
	endtask

	task automatic load_value(input int v);
		spsq_pkg::cmd_t item;
		item.op = spsq_pkg::OP_LOAD;
		item.value = v;
		send_cmd(item);
	endtask

	task automatic query_sum(input int target);
		spsq_pkg::cmd_t item;
		item.op = spsq_pkg::OP_QUERY;
		item.value = target;
		send_cmd(item);
	endtask

	task automatic send_unused(input int v);
		spsq_pkg::cmd_t item;
		item.op = spsq_pkg::op_t'(OP_UNUSED_CODE);
		item.value = v;
		send_cmd(item);
	endtask

	// Holds the command side idle until every owed answer has been checked.
	// At least one edge passes, so valid is not raised again in this step.
	task automatic wait_for_answers();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Each answer taken at an edge is compared with the oldest owed one;
	// the ready for the next cycle is then drawn in the same process.
	always @(posedge clk) begin
		spsq_pkg::res_t owed;
		if (arst_n && res_valid && res_ready) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				$display("%0t: answer with no query waiting: found=%0b first=%0d second=%0d",
					$time, res.found, res.first_value, res.second_value);
			end else begin
				owed = pending_answers.pop_front();
				if (res.found !== owed.found) begin
					mismatch_count++;
					$display("%0t: found expected %0b, actual %0b",
						$time, owed.found, res.found);
				end
				if (res.first_value !== owed.first_value) begin
					mismatch_count++;
					$display("%0t: first_value expected %0d, actual %0d",
						$time, owed.first_value, res.first_value);
				end
				if (res.second_value !== owed.second_value) begin
					mismatch_count++;
					$display("%0t: second_value expected %0d, actual %0d",
						$time, owed.second_value, res.second_value);
				end
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly small values so that pairs are common, with the range limits
	// and fully random words mixed in.
	function automatic int pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return int'($urandom_range(40)) - 20;
		if (roll < 55) begin
			case ($urandom_range(6))
				0: return VALUE_MIN;
				1: return VALUE_MIN + 1;
				2: return -1;
				3: return 0;
				4: return 1;
				5: return VALUE_MAX - 1;
				default: return VALUE_MAX;
			endcase
		end
		return int'($urandom);
	endfunction

	// Up to half the targets are the sum of two stored entries, which may be the
	// same entry twice and so probe the rule that a partner equal to a does
	// not count.
	function automatic int pick_target();
		longint sum;
		int i;
		int j;
		if (table_model.size() != 0 && $urandom_range(99) < 50) begin
			i = $urandom_range(table_model.size() - 1);
			j = $urandom_range(table_model.size() - 1);
			sum = longint'(table_model[i]) + longint'(table_model[j]);
			if (sum >= longint'(VALUE_MIN) && sum <= longint'(VALUE_MAX))
				return int'(sum);
		end
		return pick_value();
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Range limits, every op, duplicates, shifting inserts, an empty table,
	// partners outside the 32-bit range and partners equal to a.
	task automatic test_directed_cases();
		send_idle_pct = 21;
		recv_idle_pct = 86;
		clear_table();
		query_sum(0);
		send_unused(-1);
		load_value(VALUE_MAX);
		load_value(VALUE_MIN);
		load_value(5);
		load_value(5);
		load_value(-1);
		load_value(0);
		load_value(3);
		// Only five plus five would give ten, and equal partners never count.
		query_sum(10);
		query_sum(8);
		// The two range limits add up to minus one.
		query_sum(-1);
		// Minus one would need a partner just above the top of the range.
		query_sum(VALUE_MAX);
		// No stored value lies below the bottom of the range.
		query_sum(VALUE_MIN);
		query_sum(4);
		send_unused(0);
		query_sum(2);
		clear_table();
		query_sum(4);
		wait_for_answers();
	endtask

	// Builds a large table in ascending order (cheap inserts), then loads
	// the range limits so that one insert shifts every entry, finds the pair
	// of the limits, walks the table with queries that miss and clears it.
	task automatic test_large_table();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		clear_table();
		for (int i = 0; i < LARGE_TABLE_FILL; i++)
			load_value((i / 2) * 3 - 700);
		load_value(VALUE_MIN);
		load_value(VALUE_MAX);
		query_sum(table_model[0] + table_model[table_model.size()-1]);
		// Nothing pairs up, so the whole table is walked.
		query_sum(VALUE_MAX);
		query_sum(VALUE_MIN + 1);
		// Partners but the bottom limit's are in range and absent, so each is sought.
		query_sum(1);
		clear_table();
		query_sum(0);
		load_value(7);
		load_value(-7);
		query_sum(0);
		wait_for_answers();
	endtask

	// Mostly well-formed runs of clear, loads and queries with random content;
	// the rest is noise of random ops. Unused items do not count.
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int item_goal, input bit pause_midway);
		int sent;
		int loads;
		int queries;
		bit paused;
		spsq_pkg::cmd_t item;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		paused = 1'b0;
		while (sent < item_goal) begin
			if ($urandom_range(99) < 85) begin
				clear_table();
				sent++;
				loads = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(24);
				repeat (loads) begin
					load_value(pick_value());
					sent++;
				end
				queries = $urandom_range(1, 6);
				repeat (queries) begin
					case ($urandom_range(19))
						0, 1: begin
							if (table_model.size() < RANDOM_TABLE_MAX) begin
								load_value(pick_value());
								sent++;
							end
						end
						2, 3: send_unused(int'($urandom));
						4: begin
							clear_table();
							sent++;
						end
						default: begin
							query_sum(pick_target());
							sent++;
						end
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					item.op = spsq_pkg::op_t'($urandom_range(OP_UNUSED_CODE));
					item.value = ($urandom_range(1)) ? pick_value() : pick_target();
					if (item.op == spsq_pkg::OP_LOAD && table_model.size() >= RANDOM_TABLE_MAX)
						item.op = spsq_pkg::OP_QUERY;
					send_cmd(item);
					if (item.op != spsq_pkg::op_t'(OP_UNUSED_CODE))
						sent++;
				end
			end
			// Let the block drain completely once with the sender held off.
			if (pause_midway && !paused && sent >= item_goal / 2) begin
				wait_for_answers();
				paused = 1'b1;
			end
		end
		wait_for_answers();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(21, 86, 100, 1'b0);
		test_random_traffic(86, 21, 100, 1'b1);
		test_large_table();
		test_random_traffic(0, 0, 100, 1'b0);

		// A trailing load may still be shifting entries; any stray answer in
		// this window is caught by the result checker.
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
